FILE: rtl/rtc_pkg.sv
// Shared types and constants for the run-length text codec.
`timescale 1ns / 1ps

package rtc_pkg;

  // ASCII bounds of the decimal digits
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // Source of the byte loaded into the output register
  typedef enum logic [1:0] {
    SEL_TENS,
    SEL_ONES,
    SEL_FLCHAR,
    SEL_REP
  } emit_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      accept;
    logic      move;
    logic      emit;
    logic      emit_last;
    emit_sel_t sel;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mode;
    logic item_last;
    logic item_digit;
    logic fl_nz;
    logic fl_ge10;
    logic fl_gt1;
    logic rep_nz;
    logic rep_one;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/rtc_dpath.sv
// Datapath of the run-length text codec: run state, count state, output register.
`timescale 1ns / 1ps

module rtc_dpath #(
  parameter int MAX_RUN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic [7:0]       in_char,
  input  logic             in_last,
  input  rtc_pkg::ctl_cmd_t cmd,
  output rtc_pkg::dp_stat_t stat,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [7:0]       out_char,
  output logic             out_last,
  output logic             out_ovf
);

  localparam int CW = $clog2(MAX_RUN + 1);
  localparam int AW = CW + 4;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RUN);

  logic          mode_r;
  logic [7:0]    run_char_r;
  logic [CW-1:0] run_len_r;
  logic [CW-1:0] rep_cnt_r;
  logic          digits_r;
  logic          sat_r;
  logic [7:0]    fl_char_r;
  logic [CW-1:0] fl_len_r;
  logic [7:0]    item_char_r;
  logic          item_last_r;
  logic [CW-1:0] rep_left_r;
  logic          rep_ovf_r;
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_last_r;
  logic          out_ovf_r;

  logic          cont;
  logic          in_digit;
  logic [3:0]    dig_val;
  logic [7:0]    dig_diff;
  logic [AW-1:0] acc;
  logic          acc_sat;
  logic [15:0]   tens_prod;
  logic [3:0]    tens4;
  logic [7:0]    ones8;
  logic [7:0]    emit_char;

  // Run continues when the byte matches an open run below the cap
  assign cont = (run_len_r != '0) && (in_char == run_char_r) && (run_len_r < MAX_C);

  // Decimal accumulate: count * 10 + digit
  assign in_digit = (in_char >= rtc_pkg::ASCII_ZERO) && (in_char <= rtc_pkg::ASCII_NINE);
  assign dig_diff = in_char - rtc_pkg::ASCII_ZERO;
  assign dig_val  = dig_diff[3:0];
  assign acc      = ({4'b0, rep_cnt_r} << 3) + ({4'b0, rep_cnt_r} << 1)
                  + {{CW{1'b0}}, dig_val};
  assign acc_sat  = acc > AW'(MAX_RUN);

  // Split the flush length into tens and ones by reciprocal multiply
  assign tens_prod = 16'(fl_len_r) * 16'd205;
  assign tens4     = tens_prod[14:11];
  assign ones8     = 8'(fl_len_r) - (8'(tens4) * 8'd10);

  // Select the byte for the next result
  always_comb begin
    unique case (cmd.sel)
      rtc_pkg::SEL_TENS:   emit_char = rtc_pkg::ASCII_ZERO + 8'(tens4);
      rtc_pkg::SEL_ONES:   emit_char = rtc_pkg::ASCII_ZERO + 8'(ones8[3:0]);
      rtc_pkg::SEL_FLCHAR: emit_char = fl_char_r;
      rtc_pkg::SEL_REP:    emit_char = item_char_r;
      default:             emit_char = item_char_r;
    endcase
  end

  // Status to the controller
  always_comb begin
    stat.mode       = mode_r;
    stat.item_last  = item_last_r;
    stat.item_digit = (item_char_r >= rtc_pkg::ASCII_ZERO)
                   && (item_char_r <= rtc_pkg::ASCII_NINE);
    stat.fl_nz      = fl_len_r != '0;
    stat.fl_ge10    = 8'(fl_len_r) >= 8'd10;
    stat.fl_gt1     = 8'(fl_len_r) > 8'd1;
    stat.rep_nz     = rep_left_r != '0;
    stat.rep_one    = rep_left_r == CW'(1);
    stat.out_free   = !out_valid_r || out_tready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      run_char_r  <= '0;
      run_len_r   <= '0;
      rep_cnt_r   <= '0;
      digits_r    <= 1'b0;
      sat_r       <= 1'b0;
      fl_len_r    <= '0;
      rep_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end

      // Take the item for the active mode; end of text clears the count
      if (cmd.accept) begin
        if (!mode_r) begin
          if (cont) begin
            run_len_r <= run_len_r + CW'(1);
          end else begin
            fl_len_r   <= run_len_r;
            run_char_r <= in_char;
            run_len_r  <= CW'(1);
          end
        end else begin
          if (in_digit) begin
            rep_cnt_r <= acc_sat ? MAX_C : acc[CW-1:0];
            if (acc_sat) begin
              sat_r <= 1'b1;
            end
            digits_r <= 1'b1;
          end else begin
            rep_left_r <= digits_r ? rep_cnt_r : CW'(1);
            rep_cnt_r  <= '0;
            digits_r   <= 1'b0;
            sat_r      <= 1'b0;
          end
          if (in_last) begin
            run_char_r <= '0;
            run_len_r  <= '0;
          end
        end
        if (in_last) begin
          rep_cnt_r <= '0;
          digits_r  <= 1'b0;
          sat_r     <= 1'b0;
        end
      end

      // Load a result or drain the output register
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (cmd.sel == rtc_pkg::SEL_FLCHAR) begin
          fl_len_r <= '0;
        end
        if (cmd.sel == rtc_pkg::SEL_REP) begin
          rep_left_r <= rep_left_r - CW'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Hand the open run to the flush registers at end of text
      if (cmd.move) begin
        fl_len_r   <= run_len_r;
        run_char_r <= '0;
        run_len_r  <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_char_r <= in_char;
      item_last_r <= in_last;
      if (mode_r && !in_digit) begin
        rep_ovf_r <= digits_r && sat_r;
      end
      if (!mode_r && !cont) begin
        fl_char_r <= run_char_r;
      end
    end
    if (cmd.move) begin
      fl_char_r <= run_char_r;
    end
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_last_r <= cmd.emit_last;
      out_ovf_r  <= (cmd.sel == rtc_pkg::SEL_REP) ? rep_ovf_r : 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_ovf    = out_ovf_r;

endmodule

FILE: rtl/rtc_ctrl.sv
// Controller of the run-length text codec: sequences intake, flushes and repeats.
`timescale 1ns / 1ps

module rtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rtc_pkg::dp_stat_t stat,
  output rtc_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_FLUSH,
    S_TENS,
    S_ONES,
    S_CHAR,
    S_REP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   moved_r;
  logic   moved_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    moved_nxt     = moved_r;
    cmd.accept    = 1'b0;
    cmd.move      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_last = 1'b0;
    cmd.sel       = rtc_pkg::SEL_FLCHAR;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          moved_nxt  = 1'b0;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        if (!stat.mode) begin
          priority if (stat.fl_nz) begin
            state_nxt = S_FLUSH;
          end else if (stat.item_last) begin
            cmd.move  = 1'b1;
            moved_nxt = 1'b1;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = (!stat.item_digit && stat.rep_nz) ? S_REP : S_IDLE;
        end
      end
      S_FLUSH: begin
        priority if (stat.fl_ge10) begin
          state_nxt = S_TENS;
        end else if (stat.fl_gt1) begin
          state_nxt = S_ONES;
        end else begin
          state_nxt = S_CHAR;
        end
      end
      S_TENS: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = rtc_pkg::SEL_TENS;
          state_nxt = S_ONES;
        end
      end
      S_ONES: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = rtc_pkg::SEL_ONES;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = rtc_pkg::SEL_FLCHAR;
          cmd.emit_last = !stat.item_last || moved_r;
          if (stat.item_last && !moved_r) begin
            cmd.move  = 1'b1;
            moved_nxt = 1'b1;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_REP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = rtc_pkg::SEL_REP;
          cmd.emit_last = stat.rep_one;
          if (stat.rep_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and flush-order flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      moved_r <= moved_nxt;
    end
  end

endmodule

FILE: rtl/rle_text_codec.sv
// Top level of the run-length text codec.
//
//   channel | direction | ports                      | item
//   in_     | in        | tvalid tready tdata tlast  | one text byte, end-of-text flag
//   out_    | out       | tvalid tready tdata tlast  | one emitted byte, overflow in tuser
//   cfg_    | in        | we wdata                   | mode: 0 compress, 1 decompress
//
// An item passes the intake state and then the planning state. Compress then passes a
// setup state per run flush plus an emit state per emitted byte; decompress passes an
// emit state per repeated byte. A new byte is taken only when the last one is done.
// Results leave one per cycle from the output register, which stalls the sequencer while
// a result waits with out_tready low. Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module rle_text_codec #(
  parameter int MAX_RUN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic       out_tuser   // [0] overflow
);

  rtc_pkg::ctl_cmd_t cmd;
  rtc_pkg::dp_stat_t stat;

  // Sequencer
  rtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // State and output register
  rtc_dpath #(
    .MAX_RUN (MAX_RUN)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_ovf    (out_tuser)
  );

endmodule

FILE: dv/rtc_tb_pkg.sv
// Scoreboard and shared types for the run-length text codec testbench.
`timescale 1ns / 1ps

package rtc_tb_pkg;

  // Longest run or repeat count; must match the block's MAX_RUN
  localparam int RUN_CAP = 64;

  typedef enum bit {
    MODE_COMPRESS   = 1'b0,
    MODE_DECOMPRESS = 1'b1
  } codec_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } codec_byte_t;

  class codec_scoreboard;
    codec_mode_t mode;
    logic [7:0]  run_char;
    int unsigned run_len;
    int unsigned repeat_count;
    bit          digits_seen;
    bit          count_sat;
    codec_byte_t expected_bytes[$];
    codec_byte_t step_bytes[$];
    int unsigned mismatches;

    function new();
      mode = MODE_COMPRESS;
      mismatches = 0;
      clear_text();
    endfunction

    // Drop all text state; the mode register survives end of text
    function void clear_text();
      run_char = 8'h00;
      run_len = 0;
      repeat_count = 0;
      digits_seen = 0;
      count_sat = 0;
    endfunction

    function void set_mode(codec_mode_t m);
      mode = m;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void emit(logic [7:0] c, logic ovf);
      codec_byte_t b;
      b.ch = c;
      b.last = 1'b0;
      b.ovf = ovf;
      step_bytes.push_back(b);
    endfunction

    // Close the open run: decimal length when above one, then the byte
    function void close_run();
      if (run_len == 0) return;
      if (run_len > 1) begin
        if (run_len >= 10) emit(8'(rtc_pkg::ASCII_ZERO + (run_len / 10) % 10), 1'b0);
        emit(8'(rtc_pkg::ASCII_ZERO + run_len % 10), 1'b0);
      end
      emit(run_char, 1'b0);
      run_len = 0;
    endfunction

    // Advance the codec by one accepted character and queue its output bytes
    function void note_char(logic [7:0] c, logic last);
      int unsigned value;
      step_bytes.delete();
      if (mode == MODE_COMPRESS) begin
        if (run_len != 0 && c == run_char && run_len < RUN_CAP) begin
          run_len++;
        end else begin
          close_run();
          run_char = c;
          run_len = 1;
        end
        if (last) close_run();
      end else if (c >= rtc_pkg::ASCII_ZERO && c <= rtc_pkg::ASCII_NINE) begin
        value = repeat_count * 10 + (c - rtc_pkg::ASCII_ZERO);
        if (value > RUN_CAP) begin
          value = RUN_CAP;
          count_sat = 1'b1;
        end
        repeat_count = value;
        digits_seen = 1'b1;
      end else begin
        repeat (digits_seen ? repeat_count : 1) emit(c, digits_seen & count_sat);
        repeat_count = 0;
        digits_seen = 1'b0;
        count_sat = 1'b0;
      end
      if (last) clear_text();
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one output byte with the oldest expected one
    task check_byte(logic [7:0] ch, logic last, logic ovf);
      codec_byte_t want;
      if (expected_bytes.size() == 0) begin
        log_mismatch($sformatf("unexpected byte %02h last=%b ovf=%b", ch, last, ovf));
        return;
      end
      want = expected_bytes.pop_front();
      if (ch !== want.ch)
        log_mismatch($sformatf("out_char %02h, want %02h", ch, want.ch));
      if (last !== want.last)
        log_mismatch($sformatf("out_last %b, want %b (char %02h)", last, want.last, want.ch));
      if (ovf !== want.ovf)
        log_mismatch($sformatf("overflow %b, want %b (char %02h)", ovf, want.ovf, want.ch));
    endtask
  endclass

endpackage

FILE: dv/tb.sv
// Testbench top for the run-length text codec: directed and random text in both modes.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TARGET_ITEMS  = 430;

  typedef logic [7:0] text_q_t[$];

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  rtc_tb_pkg::codec_scoreboard sb;
  bit              steady;
  int unsigned     items_sent;
  int unsigned     stall_cycles;

  rle_text_codec #(
    .MAX_RUN(rtc_tb_pkg::RUN_CAP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Note accepted characters, check output bytes, stall the output at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
    end
    out_tready <= steady || ($urandom_range(0, 99) >= 34);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one character, with random idle cycles ahead of it
  task automatic send_char(logic [7:0] c, logic last);
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_text(text_q_t text, bit close);
    foreach (text[i]) send_char(text[i], close && (i == text.size() - 1));
  endtask

  // Hold input, drain all expected bytes, then let the block finish its work
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(rtc_tb_pkg::codec_mode_t m);
    settle();
    cfg_wdata <= m;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c >= rtc_pkg::ASCII_ZERO && c <= rtc_pkg::ASCII_NINE);
    return c;
  endfunction

  function automatic logic [7:0] run_byte();
    if ($urandom_range(0, 3) != 0) return 8'("a" + $urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Append one run of equal bytes; mostly short, a few past the cap
  function automatic void add_run(ref text_q_t t, input logic [7:0] c);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(1, 4);
    else if (pick < 90) len = $urandom_range(5, 15);
    else if (pick < 97) len = $urandom_range(16, 40);
    else len = $urandom_range(60, 70);
    repeat (len) t.push_back(c);
  endfunction

  // Append an optional decimal count and the byte it repeats
  function automatic void add_token(ref text_q_t t);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick >= 80) begin
      // may run past the cap and saturate
      repeat ($urandom_range(2, 3))
        t.push_back(8'(rtc_pkg::ASCII_ZERO + $urandom_range(0, 9)));
    end else if (pick >= 72) begin
      t.push_back(rtc_pkg::ASCII_ZERO);
    end else if (pick >= 57) begin
      n = $urandom_range(10, rtc_tb_pkg::RUN_CAP);
      if ($urandom_range(0, 3) == 0) t.push_back(rtc_pkg::ASCII_ZERO);
      t.push_back(8'(rtc_pkg::ASCII_ZERO + n / 10));
      t.push_back(8'(rtc_pkg::ASCII_ZERO + n % 10));
    end else if (pick >= 30) begin
      t.push_back(8'(rtc_pkg::ASCII_ZERO + $urandom_range(1, 9)));
    end
    t.push_back(non_digit());
  endfunction

  initial begin
    text_q_t     text;
    int unsigned base;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    steady = 1'b0;
    items_sent = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Compress: extreme bytes, digits as text, single byte at end of text
    write_mode(rtc_tb_pkg::MODE_COMPRESS);
    text = '{8'h00, 8'h00, 8'hFF};
    send_text(text, 1'b1);
    text = '{"5", "5", "5", "q"};
    send_text(text, 1'b1);
    text = '{"z"};
    send_text(text, 1'b1);

    // Switch mode mid-text; each mode keeps its own state
    text = '{"m", "m"};
    send_text(text, 1'b0);
    write_mode(rtc_tb_pkg::MODE_DECOMPRESS);
    text = '{"3", "k"};
    send_text(text, 1'b0);
    write_mode(rtc_tb_pkg::MODE_COMPRESS);
    text = '{"m"};
    send_text(text, 1'b1);

    // Decompress: zero count, bare byte, saturated count, trailing digit
    write_mode(rtc_tb_pkg::MODE_DECOMPRESS);
    text = '{"0", "b", "c", "9", "9", "z", 8'hFF, "7"};
    send_text(text, 1'b1);
    text = '{"2", 8'h00};
    send_text(text, 1'b1);

    // Random texts, mostly well formed, some noise
    base = items_sent;
    while (items_sent < TARGET_ITEMS) begin
      steady = (items_sent >= base + 150) && (items_sent < base + 260);
      if ($urandom_range(0, 2) == 0)
        write_mode(rtc_tb_pkg::codec_mode_t'($urandom_range(0, 1)));
      text.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 12)) text.push_back(8'($urandom_range(0, 255)));
        foreach (text[i]) send_char(text[i], $urandom_range(0, 9) == 0);
      end else begin
        if (sb.mode == rtc_tb_pkg::MODE_COMPRESS) begin
          repeat ($urandom_range(1, 6)) add_run(text, run_byte());
        end else begin
          repeat ($urandom_range(1, 5)) add_token(text);
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
              text.push_back(8'(rtc_pkg::ASCII_ZERO + $urandom_range(0, 9)));
        end
        send_text(text, $urandom_range(0, 4) != 0);
      end
    end
    steady = 1'b0;

    settle();
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
